[design/pncc_pkg.sv]
`default_nettype none
package pncc_pkg;
  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;          // accept an input beat
    logic cache_next;    // step to the next cache entry
    logic hit_take;      // capture a cache hit and keep a copy of the entry
    logic read_prev;     // read the cache entry just before the current one
    logic swap_lo;       // write the earlier entry into the current slot
    logic swap_hi;       // write the saved entry into the earlier slot
    logic search_init;   // rewind the palette index
    logic search_start;  // arm the best-distance tracker
    logic search_step;   // compare one palette entry
    logic insert;        // store the search answer in the cache
    logic emit;          // move the answer into the output register
  } pncc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic query;
    logic cache_empty;
    logic hit_match;
    logic hit_deep;
    logic cache_last;
    logic search_done;
  } pncc_sts_t;

  localparam int unsigned RGB_W = 18;
  localparam int unsigned DIST_W = 14;
  localparam int unsigned SWAP_ABOVE = 4;
endpackage
`default_nettype wire

[design/palette_nearest_color_cached.sv]
`default_nettype none
// Channel | Direction | Beat contents (tdata, low bit first)
// in_     | input     | action, entry_index[7:0], red, green, blue (27 bits in 32)
// out_    | output    | color_index[7:0], cache_hit (9 bits in 16)
//
// A palette write beat leaves the controller idle, so the input is ready again on the next cycle.
// A query walks the memo cache one entry at a time; a hit at a position above SWAP_ABOVE moves
// up one slot before the answer goes to the output register.
// A miss then compares one palette entry per cycle, up to SEARCH_LIMIT entries (at most the
// palette size), and stops early when an exact match is found. Synchronous active-low
// reset clears the controller, the cache fill count and the LFSR; memories are not cleared.
// A finished result waits in the output register. The input is ready only while idle, so it
// stalls during a query and while the next result waits for the previous one to leave.
module palette_nearest_color_cached
  import pncc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned SEARCH_LIMIT    = 254,
  parameter int unsigned CACHE_ENTRIES   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // action, entry_index, red, green, blue
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // color_index, cache_hit
);
  pncc_cmd_t cmd;
  pncc_sts_t sts;
  logic [8:0] res;

  // The controller sequences cache scan, promotion, palette search and output.
  pncc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sts(sts), .cmd(cmd)
  );

  // The datapath holds the palette, the memo cache, the LFSR and the search registers.
  pncc_dp #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES), .SEARCH_LIMIT(SEARCH_LIMIT),
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_tdata), .cmd(cmd), .sts(sts), .res(res)
  );

  // The hit flag sits just above the index; bits 15:9 are padding.
  assign out_tdata = {7'd0, res};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
  a_lfsr: assert property (@(posedge clk) disable iff (!rst_n)
    u_dp.lfsr_r != '0) else $error("lfsr locked");
endmodule

module pncc_ctrl
  import pncc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  input  wire pncc_sts_t sts,
  output pncc_cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_CRD, S_CCMP, S_SWRD, S_SWW1, S_PRD, S_PCMP, S_INS, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic pend_r;
  logic in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = pend_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        cmd.take = 1'b1;
        if (sts.query) begin
          if (sts.cache_empty) begin
            cmd.search_init = 1'b1;
            state_nxt = S_PRD;
          end else begin
            state_nxt = S_CRD;
          end
        end
      end
      S_CRD: state_nxt = S_CCMP;
      S_CCMP: begin
        if (sts.hit_match) begin
          cmd.hit_take = 1'b1;
          if (sts.hit_deep) begin
            cmd.read_prev = 1'b1;
            state_nxt = S_SWRD;
          end else begin
            state_nxt = S_OUT;
          end
        end else if (sts.cache_last) begin
          cmd.search_init = 1'b1;
          state_nxt = S_PRD;
        end else begin
          cmd.cache_next = 1'b1;
          state_nxt = S_CRD;
        end
      end
      S_SWRD: begin
        cmd.swap_lo = 1'b1;
        state_nxt = S_SWW1;
      end
      S_SWW1: begin
        cmd.swap_hi = 1'b1;
        state_nxt = S_OUT;
      end
      S_PRD: begin
        cmd.search_start = 1'b1;
        state_nxt = S_PCMP;
      end
      S_PCMP: begin
        cmd.search_step = 1'b1;
        if (sts.search_done) state_nxt = S_INS;
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (!pend_r || out_tready) begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.emit) pend_r <= 1'b1;
      else if (out_tready) pend_r <= 1'b0;
    end
  end
endmodule

module pncc_dp
  import pncc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned SEARCH_LIMIT    = 254,
  parameter int unsigned CACHE_ENTRIES   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] in_data,
  input  wire pncc_cmd_t   cmd,
  output pncc_sts_t        sts,
  output logic [8:0]       res
);
  localparam int unsigned PA = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int unsigned LIM0 = (SEARCH_LIMIT > PALETTE_ENTRIES) ?
                                 PALETTE_ENTRIES : SEARCH_LIMIT;
  localparam int unsigned LIM = (LIM0 < 1) ? 1 : LIM0;
  localparam int unsigned CA = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned CEW = RGB_W + 8;

  logic [RGB_W-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic [CA-1:0] ci_r;
  logic [8:0] pi_r;
  logic [14:0] lfsr_r;
  logic [DIST_W-1:0] best_r;
  logic [7:0] bidx_r, ans_r;
  logic hit_r, ov_r;
  logic [CEW-1:0] swap_r;
  logic [8:0] res_r;

  logic [RGB_W-1:0] in_rgb;
  logic pal_ok, pal_we;
  logic [PA-1:0] pw_addr, pr_addr;
  logic [RGB_W-1:0] p_rd;
  logic c_we;
  logic [CA-1:0] c_wa, c_ra;
  logic [CEW-1:0] c_wd, c_rd;
  logic [14:0] lfsr_n;
  logic [CA-1:0] slot;
  logic [21:0] slot_w;
  logic [DIST_W-1:0] sum_sq;
  logic [6:0] dr, dg, db;
  logic better, done;

  assign in_rgb = {in_data[14:9], in_data[20:15], in_data[26:21]};
  assign pal_ok = {1'b0, in_data[8:1]} < 9'(PALETTE_ENTRIES);
  assign pal_we = cmd.take && !in_data[0] && pal_ok;
  assign pw_addr = in_data[1+PA-1:1];
  // While comparing, the address runs one entry ahead so the registered read lines up.
  assign pr_addr = PA'(pi_r + 9'(cmd.search_step));

  pncc_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_ENTRIES)) u_pal (
    .clk(clk), .we(pal_we), .waddr(pw_addr), .wdata(in_rgb),
    .raddr(pr_addr), .rdata(p_rd));

  pncc_ram #(.WIDTH(CEW), .DEPTH(CACHE_ENTRIES)) u_cache (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

  assign lfsr_n = {lfsr_r[13:0], lfsr_r[14] ^ lfsr_r[13]};
  assign slot_w = 22'(lfsr_n) * 22'(CACHE_ENTRIES);
  assign slot = CA'(slot_w >> 15);

  assign dr = 7'(q_r[17:12]) - 7'(p_rd[17:12]);
  assign dg = 7'(q_r[11:6]) - 7'(p_rd[11:6]);
  assign db = 7'(q_r[5:0]) - 7'(p_rd[5:0]);
  function automatic logic [11:0] sq(input logic [6:0] d);
    logic [5:0] a;
    a = d[6] ? 6'(-d) : d[5:0];
    return 12'(a) * 12'(a);
  endfunction
  assign sum_sq = DIST_W'(sq(dr)) + DIST_W'(sq(dg)) + DIST_W'(sq(db));

  assign better = ov_r || (sum_sq < best_r);
  assign done = (better && sum_sq == '0) || (pi_r + 9'd1 >= 9'(LIM));

  always_comb begin
    sts.query = in_data[0];
    sts.cache_empty = (cnt_r == '0);
    sts.hit_match = (c_rd[CEW-1:8] == q_r);
    sts.hit_deep = (32'(ci_r) > SWAP_ABOVE);
    sts.cache_last = ((CW'(ci_r) + CW'(1)) >= cnt_r);
    sts.search_done = done;
  end

  // A promotion reads the earlier entry, writes it into the hit slot, then writes the
  // saved hit entry into the earlier slot.
  always_comb begin
    c_ra = ci_r;
    c_we = 1'b0;
    c_wa = ci_r;
    c_wd = c_rd;
    if (cmd.read_prev) c_ra = ci_r - 1'b1;
    if (cmd.swap_lo) c_we = 1'b1;
    if (cmd.swap_hi) begin
      c_we = 1'b1;
      c_wa = ci_r - 1'b1;
      c_wd = swap_r;
    end
    if (cmd.insert) begin
      c_we = 1'b1;
      c_wd = {q_r, bidx_r};
      c_wa = (cnt_r < CW'(CACHE_ENTRIES)) ? CA'(cnt_r) : slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lfsr_r <= 15'd1;
    end else begin
      if (cmd.take) begin
        q_r <= in_rgb;
        ci_r <= '0;
        if (!in_data[0] && pal_ok) cnt_r <= '0;
      end
      if (cmd.cache_next) ci_r <= ci_r + 1'b1;
      if (cmd.hit_take) begin
        ans_r <= c_rd[7:0];
        hit_r <= 1'b1;
        swap_r <= c_rd;
      end
      if (cmd.search_init) pi_r <= '0;
      if (cmd.search_start) begin
        best_r <= '1;
        bidx_r <= '0;
        ov_r <= 1'b1;
      end
      if (cmd.search_step) begin
        if (better) begin
          best_r <= sum_sq;
          bidx_r <= 8'(pi_r);
        end
        ov_r <= 1'b0;
        if (!done) pi_r <= pi_r + 1'b1;
      end
      if (cmd.insert) begin
        if (cnt_r < CW'(CACHE_ENTRIES)) cnt_r <= cnt_r + 1'b1;
        else lfsr_r <= lfsr_n;
        ans_r <= bidx_r;
        hit_r <= 1'b0;
      end
      if (cmd.emit) res_r <= {hit_r, ans_r};
    end
  end

  assign res = res_r;
endmodule
`default_nettype wire

[design/pncc_ram.sv]
`default_nettype none
module pncc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                            clk,
  input  wire logic                                            we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                                wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                                rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
